@@ src/isu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isu_pkg
// Shared types and constants for the image sample unpacker.
// ----------------------------------------------------------------------------
package isu_pkg;

    localparam int ROW_COUNT_BITS = 16;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // log2 of the component width
    typedef enum logic [1:0] {
        WIDTH_1 = 2'd0,
        WIDTH_2 = 2'd1,
        WIDTH_4 = 2'd2,
        WIDTH_8 = 2'd3
    } width_code_t;

    typedef enum logic [1:0] {
        CFG_BITS_PER_COMPONENT = 2'd0,
        CFG_COMPONENTS_PER_ROW = 2'd1,
        CFG_SCALE_ENABLE       = 2'd2
    } cfg_index_t;

    // one classified request on its way from front to back
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        stream_finish;
        width_code_t width;
        logic        scale;
    } isu_entry_t;

    typedef struct packed {
        logic full;
        logic head_valid;
    } isu_queue_status_t;

endpackage

`default_nettype wire

@@ src/isu_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isu_front
// Configuration registers, input handshake and width classification.
// ----------------------------------------------------------------------------
module isu_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [15:0]               cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [7:0]                data_byte,
    input  wire logic                      stream_finish,
    input  wire isu_pkg::isu_queue_status_t q_status,
    output logic                           push,
    output isu_pkg::isu_entry_t            push_entry,
    output logic [15:0]                    components_per_row
);
    import isu_pkg::*;

    logic [3:0]  bpc_reg;
    logic [15:0] cpr_reg;
    logic        scale_reg;
    width_code_t width;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpc_reg   <= 4'd8;
            cpr_reg   <= 16'd1;
            scale_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_BITS_PER_COMPONENT: bpc_reg   <= cfg_data[3:0];
                CFG_COMPONENTS_PER_ROW: cpr_reg   <= cfg_data;
                CFG_SCALE_ENABLE:       scale_reg <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    // unsupported widths unpack as 8 bits
    always_comb
    begin
        case (bpc_reg)
            4'd1:    width = WIDTH_1;
            4'd2:    width = WIDTH_2;
            4'd4:    width = WIDTH_4;
            default: width = WIDTH_8;
        endcase
    end

    assign in_stall                 = q_status.full;
    assign push                     = in_valid && !q_status.full;
    assign push_entry.data_byte     = data_byte;
    assign push_entry.stream_finish = stream_finish;
    assign push_entry.width         = width;
    assign push_entry.scale         = scale_reg;
    assign components_per_row       = cpr_reg;

endmodule

`default_nettype wire

@@ src/isu_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isu_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module isu_queue (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    input  wire isu_pkg::isu_entry_t       push_entry,
    input  wire logic                      pop,
    output isu_pkg::isu_queue_status_t     status,
    output isu_pkg::isu_entry_t            head
);
    import isu_pkg::*;

    isu_entry_t                entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_BITS-1:0] count_reg;
    logic [QUEUE_CNT_BITS-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

    assign status.full       = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign status.head_valid = (count_reg != '0);
    assign head              = entries_reg[rd_ptr_reg];

endmodule

`default_nettype wire

@@ src/isu_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isu_back
// Splits the head byte into components, one per cycle while the output is
// not stalled, tracks the row position and holds the result in an output register.
// ----------------------------------------------------------------------------
module isu_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire isu_pkg::isu_queue_status_t q_status,
    input  wire isu_pkg::isu_entry_t       head,
    output logic                           pop,
    input  wire logic [15:0]               components_per_row,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [7:0]                     component,
    output logic                           row_end,
    output logic                           stream_end,
    output logic                           last_of_run
);
    import isu_pkg::*;

    logic [2:0]                idx_reg;
    logic [ROW_COUNT_BITS-1:0] row_pos_reg;
    logic [ROW_COUNT_BITS-1:0] row_pos_next;
    logic                      out_valid_reg;
    logic [7:0]                comp_reg;
    logic                      row_end_reg;
    logic                      stream_end_reg;
    logic                      last_reg;

    logic       issue;
    logic [2:0] shamt;
    logic [2:0] last_idx;
    logic [7:0] shifted;
    logic [7:0] comp_val;
    logic       rend;
    logic       last;

    assign issue    = q_status.head_valid && (!out_valid_reg || !out_stall);
    assign shamt    = 3'(idx_reg << head.width);
    assign last_idx = 3'(3'd7 >> head.width);
    assign shifted  = 8'(head.data_byte << shamt);

    // scaling by 255/(2^w-1) is the same as repeating the component bits
    always_comb
    begin
        case (head.width)
            WIDTH_1: comp_val = head.scale ? {8{shifted[7]}}   : {7'd0, shifted[7]};
            WIDTH_2: comp_val = head.scale ? {4{shifted[7:6]}} : {6'd0, shifted[7:6]};
            WIDTH_4: comp_val = head.scale ? {2{shifted[7:4]}} : {4'd0, shifted[7:4]};
            default: comp_val = shifted;
        endcase
    end

    assign row_pos_next = row_pos_reg + 1'b1;
    assign rend         = (row_pos_next == ROW_COUNT_BITS'(components_per_row));
    // a row end drops the rest of the byte
    assign last         = rend || (idx_reg == last_idx);
    assign pop          = issue && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            row_pos_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                idx_reg       <= last ? 3'd0 : idx_reg + 1'b1;
                row_pos_reg   <= rend ? '0 : row_pos_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            comp_reg       <= comp_val;
            row_end_reg    <= rend;
            stream_end_reg <= last && head.stream_finish;
            last_reg       <= last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign component   = comp_reg;
    assign row_end     = row_end_reg;
    assign stream_end  = stream_end_reg;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire

@@ src/image_sample_unpacker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// image_sample_unpacker
// Unpacks image bytes, MSB first, into 1, 2, 4 or 8 bit components.
// ----------------------------------------------------------------------------
// Each input byte yields 8/w components (8, 4, 2 or 1 for widths 1, 2, 4, 8),
// fewer when a row ends inside the byte, and the unpack stage emits one
// component per cycle while the output is not stalled, so a byte stays in the
// queue until its last component is issued. A two-entry request queue sits
// between the input side and the unpack stage, so up to two bytes are taken
// while results are still draining; the output register holds a stalled
// result, and the next one is formed in the same cycle the current one is taken.
module image_sample_unpacker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        stream_finish,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       component,
    output logic             row_end,
    output logic             stream_end,
    output logic             last_of_run
);
    import isu_pkg::*;

    isu_queue_status_t q_status;
    isu_entry_t        push_entry;
    isu_entry_t        head;
    logic              push;
    logic              pop;
    logic [15:0]       components_per_row;

    isu_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .data_byte          (data_byte),
        .stream_finish      (stream_finish),
        .q_status           (q_status),
        .push               (push),
        .push_entry         (push_entry),
        .components_per_row (components_per_row)
    );

    isu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .status     (q_status),
        .head       (head)
    );

    isu_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .q_status           (q_status),
        .head               (head),
        .pop                (pop),
        .components_per_row (components_per_row),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .component          (component),
        .row_end            (row_end),
        .stream_end         (stream_end),
        .last_of_run        (last_of_run)
    );

endmodule

`default_nettype wire

@@ verif/image_sample_unpacker_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_sample_unpacker_test
// Self-checking bench for the image sample unpacker. Packed bytes are fed
// through a request queue with random idle bursts on both sides. A local
// bit-accurate predictor expands each accepted byte into expected components
// that are checked in order against the results.
// ----------------------------------------------------------------------------
module image_sample_unpacker_test;
    import isu_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_BYTES   = 30;
    localparam int HOLD_CYCLES   = 90;
    localparam logic [1:0] CFG_SPARE_INDEX = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       finish;
    } byte_req_t;

    typedef struct packed {
        logic [7:0] value;
        logic       row_end;
        logic       stream_end;
        logic       last_of_run;
    } component_rec_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_write     = 1'b0;
    logic [1:0]  cfg_index     = '0;
    logic [15:0] cfg_data      = '0;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte     = '0;
    logic        stream_finish = 1'b0;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic [7:0]  component;
    logic        row_end;
    logic        stream_end;
    logic        last_of_run;

    // predictor copy of the registers and unpack state
    logic [3:0]  cur_bits    = 4'd8;
    logic [15:0] cur_row_len = 16'd1;
    logic        cur_scale   = 1'b0;
    logic [15:0] bit_store   = '0;
    logic [3:0]  bits_held   = '0;
    logic [15:0] row_count   = '0;

    byte_req_t      pending_bytes[$];
    component_rec_t expected_components[$];
    byte_req_t      next_req;
    component_rec_t oldest;

    int errors       = 0;
    int bytes_taken  = 0;
    int results_seen = 0;
    int rows_seen    = 0;
    int streams_seen = 0;
    int cycle_count  = 0;
    int idle_odds    = 20;
    int src_gap      = 0;
    int sink_gap     = 0;
    int hold_left    = 0;
    logic sink_hold  = 1'b0;

    image_sample_unpacker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .stream_finish (stream_finish),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .component     (component),
        .row_end       (row_end),
        .stream_end    (stream_end),
        .last_of_run   (last_of_run)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        errors++;
    endtask

    function automatic width_code_t width_code(input logic [3:0] bpc);
        case (bpc)
            4'd1:    return WIDTH_1;
            4'd2:    return WIDTH_2;
            4'd4:    return WIDTH_4;
            default: return WIDTH_8;
        endcase
    endfunction

    // Expand one accepted byte into its components, MSB first.
    task automatic unpack_byte(input logic [7:0] b, input logic fin);
        width_code_t    code;
        int             w;
        int             factor;
        int             comp;
        int             n;
        logic [15:0]    nxt;
        component_rec_t burst[8];
        code = width_code(cur_bits);
        w = 1 << int'(code);
        case (code)
            WIDTH_1: factor = 255;
            WIDTH_2: factor = 85;
            WIDTH_4: factor = 17;
            default: factor = 1;
        endcase
        n = 0;
        bit_store = {bit_store[7:0], b};
        bits_held = bits_held + 4'd8;
        while (int'(bits_held) >= w && n < 8)
        begin
            bits_held = bits_held - 4'(w);
            comp = (int'(bit_store) >> bits_held) & ((1 << w) - 1);
            bit_store = bit_store & 16'((1 << bits_held) - 1);
            if (cur_scale)
                comp = comp * factor;
            nxt = row_count + 16'd1;
            burst[n] = '{value: 8'(comp), row_end: 1'b0, stream_end: 1'b0,
                         last_of_run: 1'b0};
            // row end drops whatever is left of the current byte
            if (nxt == cur_row_len)
            begin
                burst[n].row_end = 1'b1;
                row_count = '0;
                bits_held = '0;
                bit_store = '0;
            end
            else
                row_count = nxt;
            n++;
        end
        burst[n - 1].stream_end  = fin;
        burst[n - 1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            expected_components.push_back(burst[i]);
    endtask

    // sender side
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                unpack_byte(data_byte, stream_finish);
                bytes_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    in_valid <= 1'b0;
                end
                else if (idle_odds > 0 && $urandom_range(0, 99) < idle_odds)
                begin
                    src_gap = $urandom_range(0, 6);
                    in_valid <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    next_req = pending_bytes.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= next_req.data;
                    stream_finish <= next_req.finish;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver side: check results and drive stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (row_end)
                rows_seen++;
            if (stream_end)
                streams_seen++;
            if (expected_components.size() == 0)
                report_mismatch($sformatf("result %02h/%b%b%b with nothing expected",
                                          component, row_end, stream_end, last_of_run));
            else
            begin
                oldest = expected_components.pop_front();
                if ({component, row_end, stream_end, last_of_run} !== oldest)
                    report_mismatch($sformatf(
                        "component %02h row_end %b stream_end %b last %b, wanted %02h %b %b %b",
                        component, row_end, stream_end, last_of_run, oldest.value,
                        oldest.row_end, oldest.stream_end, oldest.last_of_run));
            end
        end
        if (sink_gap > 0)
            sink_gap--;
        else if (idle_odds > 0 && $urandom_range(0, 99) < idle_odds)
            sink_gap = $urandom_range(1, 7);
        out_stall <= sink_hold || (sink_gap > 0);
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            sink_hold <= 1'b1;
        end
        else
            sink_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles, %0d results outstanding",
                     cycle_count, expected_components.size());
            $display("[image_sample_unpacker] ERROR");
            $finish;
        end
    end

    // sampled at the falling edge so the driver and checker have settled
    task automatic wait_idle();
        @(negedge clk);
        while (pending_bytes.size() != 0 || in_valid || expected_components.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_BITS_PER_COMPONENT: cur_bits    = val[3:0];
            CFG_COMPONENTS_PER_ROW: cur_row_len = val;
            CFG_SCALE_ENABLE:       cur_scale   = val[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // upper data bits of the narrow registers are junk on purpose
    task automatic apply_config(input logic [3:0] bpc, input logic [15:0] cpr,
                                input logic scale);
        wait_idle();
        write_reg(CFG_BITS_PER_COMPONENT, {12'($urandom), bpc});
        write_reg(CFG_COMPONENTS_PER_ROW, cpr);
        write_reg(CFG_SCALE_ENABLE, {15'($urandom), scale});
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic fin);
        pending_bytes.push_back('{data: b, finish: fin});
    endtask

    task automatic random_phase(input int count);
        logic [3:0]  bpc;
        logic [15:0] cpr;
        if ($urandom_range(0, 9) < 2)
            bpc = 4'($urandom);
        else
            bpc = 4'(1 << $urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0:       cpr = 16'($urandom);
            1:       cpr = '0;
            2:       cpr = '1;
            default: cpr = 16'($urandom_range(1, 24));
        endcase
        apply_config(bpc, cpr, 1'($urandom));
        repeat (count) queue_byte(8'($urandom), $urandom_range(0, 7) == 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: whole bytes, one per row
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hA5, 1'b0);

        // single bits, scaled; the row ends inside the second byte
        apply_config(4'd1, 16'd12, 1'b1);
        write_reg(CFG_SPARE_INDEX, 16'($urandom));
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h01, 1'b1);

        apply_config(4'd2, 16'd3, 1'b1);
        queue_byte(8'hE4, 1'b0);
        queue_byte(8'h1B, 1'b1);

        // zero row length: rows of 65536 components
        apply_config(4'd4, 16'd0, 1'b0);
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'h0F, 1'b1);

        // unsupported widths fall back to whole bytes
        apply_config(4'd0, 16'hFFFF, 1'b1);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'h80, 1'b1);

        apply_config(4'd15, 16'd2, 1'b0);
        queue_byte(8'h55, 1'b0);
        queue_byte(8'hAA, 1'b1);

        apply_config(4'd4, 16'd5, 1'b1);
        queue_byte(8'h3C, 1'b0);
        queue_byte(8'hC3, 1'b0);
        queue_byte(8'h96, 1'b1);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case ($urandom_range(0, 2))
                0:       idle_odds = 0;
                1:       idle_odds = 15;
                default: idle_odds = 35;
            endcase
            if (p == RANDOM_PHASES - 1)
                idle_odds = 0;
            random_phase(PHASE_BYTES);
            if (p == 1)
            begin
                @(negedge clk);
                hold_left = HOLD_CYCLES;
            end
        end

        wait_idle();
        $display("%0d bytes unpacked into %0d components across several widths and row lengths",
                 bytes_taken, results_seen);
        $display("%0d row ends and %0d stream ends seen, %0d mismatches",
                 rows_seen, streams_seen, errors);
        if (errors == 0)
            $display("[image_sample_unpacker] OK");
        else
            $display("[image_sample_unpacker] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
src/isu_pkg.sv
src/isu_front.sv
src/isu_queue.sv
src/isu_back.sv
src/image_sample_unpacker.sv
verif/image_sample_unpacker_test.sv
